// ===== rtl/core/batt_pkg.sv =====
// ----------------------------------------------------------------------------
// batt_pkg
// Shared types and constants for the battery level estimator.
// ----------------------------------------------------------------------------
package batt_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int LEVEL_BITS  = 7;
   localparam int LOW_BITS    = 4;
   localparam int STEP_BITS   = 3;
   localparam int QUOT_BITS   = 7;
   // 200 * num + den < 2^(SAMPLE_BITS + 8)
   localparam int REM_BITS    = SAMPLE_BITS + 8;
   localparam int DVS_BITS    = SAMPLE_BITS + 1;

   localparam logic [LEVEL_BITS-1:0]  FULL_LEVEL = LEVEL_BITS'(100);
   localparam logic [LOW_BITS-1:0]    LOW_LIMIT  = LOW_BITS'(9);
   localparam logic [LOW_BITS-1:0]    LOW_SAT    = LOW_BITS'(10);
   localparam logic [SAMPLE_BITS-1:0] MIN_RESET  = SAMPLE_BITS'(3000);
   localparam logic [SAMPLE_BITS-1:0] MAX_RESET  = SAMPLE_BITS'(4000);

   localparam logic [STEP_BITS-1:0] SORT_LAST = STEP_BITS'(4);
   localparam logic [STEP_BITS-1:0] DIV_FIRST = STEP_BITS'(QUOT_BITS - 1);

   typedef enum logic {
      CSR_MIN_MV = 1'b0,
      CSR_MAX_MV = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT,
      ST_MEAN,
      ST_CMP_MAX,
      ST_CMP_MIN,
      ST_SUB_NUM,
      ST_SUB_DEN,
      ST_SETUP,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      BR_ZERO,
      BR_LOW,
      BR_PCT,
      BR_FULL
   } branch_type;

   typedef struct packed {
      logic [REM_BITS-1:0] op_a;
      logic [REM_BITS-1:0] op_b;
   } alu_in_type;

   typedef struct packed {
      logic                ge;
      logic [REM_BITS-1:0] diff;
   } alu_out_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] min_mv;
      logic [SAMPLE_BITS-1:0] max_mv;
   } csr_type;

endpackage

// ===== rtl/core/batt_req_if.sv =====
// ----------------------------------------------------------------------------
// batt_req_if
// Request channel: one measurement round of four samples.
// ----------------------------------------------------------------------------
interface batt_req_if;
   import batt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_a;
   logic [SAMPLE_BITS-1:0] sample_b;
   logic [SAMPLE_BITS-1:0] sample_c;
   logic [SAMPLE_BITS-1:0] sample_d;

   modport source (output valid, sample_a, sample_b, sample_c, sample_d, input ready);
   modport sink   (input valid, sample_a, sample_b, sample_c, sample_d, output ready);

endinterface

// ===== rtl/core/batt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// batt_rsp_if
// Response channel: filtered voltage, level and status flags.
// ----------------------------------------------------------------------------
interface batt_rsp_if;
   import batt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] filtered_millivolts;
   logic [LEVEL_BITS-1:0]  level_percent;
   logic                   level_valid;
   logic                   level_changed;
   logic                   sleep_request;

   modport source (output valid, filtered_millivolts, level_percent, level_valid,
                   level_changed, sleep_request, input ready);
   modport sink   (input valid, filtered_millivolts, level_percent, level_valid,
                   level_changed, sleep_request, output ready);

endinterface

// ===== rtl/core/batt_alu.sv =====
// ----------------------------------------------------------------------------
// batt_alu
// Shared subtract/compare unit used for sorting, range checks and division.
// ----------------------------------------------------------------------------
module batt_alu (
   input  batt_pkg::alu_in_type  alu_in,
   output batt_pkg::alu_out_type alu_out
);
   import batt_pkg::*;

   logic [REM_BITS:0] diff_wide;

   assign diff_wide    = {1'b0, alu_in.op_a} - {1'b0, alu_in.op_b};
   assign alu_out.ge   = ~diff_wide[REM_BITS];
   assign alu_out.diff = diff_wide[REM_BITS-1:0];

endmodule

// ===== rtl/core/batt_seq.sv =====
// ----------------------------------------------------------------------------
// batt_seq
// Sequencer and datapath registers: sort, mean, range check, restoring
// division for the percentage, and state update.
// ----------------------------------------------------------------------------
module batt_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  batt_pkg::csr_type     csr,
   output batt_pkg::alu_in_type  alu_in,
   input  batt_pkg::alu_out_type alu_out,
   batt_req_if.sink              req_bus,
   batt_rsp_if.source            rsp_bus
);
   import batt_pkg::*;

   localparam int PAD = REM_BITS - SAMPLE_BITS;

   state_type              state_ff, state_in;
   branch_type             branch_ff, branch_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [SAMPLE_BITS-1:0] samp_ff [4];
   logic [SAMPLE_BITS-1:0] samp_in [4];
   logic [SAMPLE_BITS-1:0] filt_ff, filt_in;
   logic [SAMPLE_BITS-1:0] num_ff, num_in;
   logic [SAMPLE_BITS-1:0] den_ff, den_in;
   logic [REM_BITS-1:0]    rem_ff, rem_in;
   logic [DVS_BITS-1:0]    dvs_ff, dvs_in;
   logic [QUOT_BITS-1:0]   quot_ff, quot_in;
   logic [LEVEL_BITS-1:0]  stored_ff, stored_in;
   logic [LOW_BITS-1:0]    low_ff, low_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_filt_ff, rsp_filt_in;
   logic [LEVEL_BITS-1:0]  rsp_level_ff, rsp_level_in;
   logic                   rsp_lvalid_ff, rsp_lvalid_in;
   logic                   rsp_changed_ff, rsp_changed_in;
   logic                   rsp_sleep_ff, rsp_sleep_in;

   logic [1:0]             lo_idx, hi_idx;
   logic                   accept;
   logic                   load_rsp;
   logic                   lvl_valid;
   logic                   lvl_changed;
   logic [LOW_BITS-1:0]    low_next;
   logic [SAMPLE_BITS:0]   mid_sum;
   logic [REM_BITS-1:0]    num_ext;

   // compare-exchange pairs of the four-input sorting network
   always_comb begin
      unique case (step_ff)
         3'd0:    begin lo_idx = 2'd0; hi_idx = 2'd1; end
         3'd1:    begin lo_idx = 2'd2; hi_idx = 2'd3; end
         3'd2:    begin lo_idx = 2'd0; hi_idx = 2'd2; end
         3'd3:    begin lo_idx = 2'd1; hi_idx = 2'd3; end
         default: begin lo_idx = 2'd1; hi_idx = 2'd2; end
      endcase
   end

   assign accept   = req_bus.valid && req_bus.ready;
   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_bus.valid) state_in = ST_SORT;
         ST_SORT:    if (step_ff == SORT_LAST) state_in = ST_MEAN;
         ST_MEAN:    state_in = ST_CMP_MAX;
         ST_CMP_MAX: state_in = alu_out.ge ? ST_CMP_MIN : ST_FINISH;
         ST_CMP_MIN: state_in = alu_out.ge ? ST_FINISH : ST_SUB_NUM;
         ST_SUB_NUM: state_in = ST_SUB_DEN;
         ST_SUB_DEN: state_in = ST_SETUP;
         ST_SETUP:   state_in = ST_DIV;
         ST_DIV:     if (step_ff == '0) state_in = ST_FINISH;
         ST_FINISH:  if (load_rsp) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs: shared unit operands and request ready
   always_comb begin
      alu_in.op_a     = '0;
      alu_in.op_b     = '0;
      req_bus.ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_bus.ready = 1'b1;
         ST_SORT: begin
            alu_in.op_a = {{PAD{1'b0}}, samp_ff[hi_idx]};
            alu_in.op_b = {{PAD{1'b0}}, samp_ff[lo_idx]};
         end
         ST_CMP_MAX: begin
            alu_in.op_a = {{PAD{1'b0}}, csr.max_mv};
            alu_in.op_b = {{PAD{1'b0}}, filt_ff};
         end
         ST_CMP_MIN: begin
            alu_in.op_a = {{PAD{1'b0}}, csr.min_mv};
            alu_in.op_b = {{PAD{1'b0}}, filt_ff};
         end
         ST_SUB_NUM: begin
            alu_in.op_a = {{PAD{1'b0}}, filt_ff};
            alu_in.op_b = {{PAD{1'b0}}, csr.min_mv};
         end
         ST_SUB_DEN: begin
            alu_in.op_a = {{PAD{1'b0}}, csr.max_mv};
            alu_in.op_b = {{PAD{1'b0}}, csr.min_mv};
         end
         ST_DIV: begin
            alu_in.op_a = rem_ff;
            alu_in.op_b = {{(REM_BITS-DVS_BITS){1'b0}}, dvs_ff} << step_ff;
         end
         default: ;
      endcase
   end

   // result of the round
   assign lvl_valid   = (branch_ff == BR_FULL) || (branch_ff == BR_PCT);
   assign lvl_changed = lvl_valid && (quot_ff != stored_ff);
   assign low_next    = (low_ff < LOW_SAT) ? low_ff + LOW_BITS'(1) : low_ff;
   assign mid_sum     = {1'b0, samp_ff[1]} + {1'b0, samp_ff[2]};
   assign num_ext     = {{PAD{1'b0}}, num_ff};

   // datapath next values
   always_comb begin
      step_in        = step_ff;
      branch_in      = branch_ff;
      samp_in        = samp_ff;
      filt_in        = filt_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      quot_in        = quot_ff;
      stored_in      = stored_ff;
      low_in         = low_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_filt_in    = rsp_filt_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_lvalid_in  = rsp_lvalid_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_sleep_in   = rsp_sleep_ff;

      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               samp_in[0] = req_bus.sample_a;
               samp_in[1] = req_bus.sample_b;
               samp_in[2] = req_bus.sample_c;
               samp_in[3] = req_bus.sample_d;
               step_in    = '0;
            end
         end
         ST_SORT: begin
            if (!alu_out.ge) begin
               samp_in[lo_idx] = samp_ff[hi_idx];
               samp_in[hi_idx] = samp_ff[lo_idx];
            end
            step_in = step_ff + STEP_BITS'(1);
         end
         ST_MEAN:    filt_in = mid_sum[SAMPLE_BITS:1];
         ST_CMP_MAX: begin
            branch_in = BR_FULL;
            quot_in   = QUOT_BITS'(FULL_LEVEL);
         end
         ST_CMP_MIN: begin
            if (!alu_out.ge) begin
               branch_in = BR_PCT;
               quot_in   = '0;
            end else begin
               branch_in = (filt_ff == '0) ? BR_ZERO : BR_LOW;
            end
         end
         ST_SUB_NUM: num_in = alu_out.diff[SAMPLE_BITS-1:0];
         ST_SUB_DEN: den_in = alu_out.diff[SAMPLE_BITS-1:0];
         ST_SETUP: begin
            // 200 * num + den, divided by 2 * den
            rem_in  = (num_ext << 7) + (num_ext << 6) + (num_ext << 3)
                      + {{PAD{1'b0}}, den_ff};
            dvs_in  = {den_ff, 1'b0};
            step_in = DIV_FIRST;
         end
         ST_DIV: begin
            if (alu_out.ge) begin
               rem_in           = alu_out.diff;
               quot_in[step_ff] = 1'b1;
            end
            step_in = step_ff - STEP_BITS'(1);
         end
         ST_FINISH: begin
            if (load_rsp) begin
               if (lvl_changed) stored_in = quot_ff;
               if (lvl_valid) low_in = '0;
               else if (branch_ff == BR_LOW) low_in = low_next;
               rsp_valid_in   = 1'b1;
               rsp_filt_in    = filt_ff;
               rsp_level_in   = lvl_changed ? quot_ff : stored_ff;
               rsp_lvalid_in  = lvl_valid;
               rsp_changed_in = lvl_changed;
               rsp_sleep_in   = (branch_ff == BR_LOW) && (low_next > LOW_LIMIT);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stored_ff    <= '0;
         low_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      branch_ff      <= branch_in;
      samp_ff        <= samp_in;
      filt_ff        <= filt_in;
      num_ff         <= num_in;
      den_ff         <= den_in;
      rem_ff         <= rem_in;
      dvs_ff         <= dvs_in;
      quot_ff        <= quot_in;
      rsp_filt_ff    <= rsp_filt_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_lvalid_ff  <= rsp_lvalid_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_sleep_ff   <= rsp_sleep_in;
   end

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.filtered_millivolts = rsp_filt_ff;
   assign rsp_bus.level_percent       = rsp_level_ff;
   assign rsp_bus.level_valid         = rsp_lvalid_ff;
   assign rsp_bus.level_changed       = rsp_changed_ff;
   assign rsp_bus.sleep_request       = rsp_sleep_ff;

   a_low_sat: assert property (@(posedge clock) disable iff (reset)
      low_ff <= LOW_SAT)
      else $error("low round counter above saturation");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= FULL_LEVEL)
      else $error("stored level above full");

   a_changed_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_changed_ff) |-> rsp_lvalid_ff)
      else $error("level change flagged without a level");

   a_sleep_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sleep_ff) |-> (!rsp_lvalid_ff && low_ff > LOW_LIMIT))
      else $error("sleep request without saturated low rounds");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("result load did not return to idle");

endmodule

// ===== rtl/core/battery_level_estimator.sv =====
// ----------------------------------------------------------------------------
// battery_level_estimator
// Trimmed mean of four samples mapped to a battery percentage.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one round of four millivolt samples; rsp_bus returns one
//   response per request with the filtered voltage, the last reported level
//   and the valid, changed and sleep flags. csr_* writes the min and max
//   thresholds; write them only while no request is in flight.
// Timing:
//   A request skips the division when the filtered value is above max or
//   at or below min or zero; the division runs only when a percentage is
//   computed. All compares and subtractions run through one shared
//   subtract/compare unit: five sorting steps, the range checks, the two
//   subtractions and seven restoring division steps. One request is in flight
//   at a time; the next is accepted the cycle after the response is loaded.
// Reset:
//   Synchronous, active high. Thresholds return to 3000 and 4000 mV, the
//   stored level and low round counter to zero, and no response is pending.
// Backpressure:
//   The response register holds while rsp_bus.ready is low; a finished
//   request waits in the sequencer until the register is free.
// ----------------------------------------------------------------------------
module battery_level_estimator (
   input  logic                             clock,
   input  logic                             reset,
   batt_req_if.sink                         req_bus,
   batt_rsp_if.source                       rsp_bus,
   input  logic                             csr_write_enable,
   input  logic                             csr_index,
   input  logic [batt_pkg::SAMPLE_BITS-1:0] csr_write_data
);
   import batt_pkg::*;

   logic [SAMPLE_BITS-1:0] min_mv_ff, min_mv_in;
   logic [SAMPLE_BITS-1:0] max_mv_ff, max_mv_in;
   csr_type                csr;
   alu_in_type             alu_in;
   alu_out_type            alu_out;

   always_comb begin
      min_mv_in = min_mv_ff;
      max_mv_in = max_mv_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_MV: min_mv_in = csr_write_data;
            CSR_MAX_MV: max_mv_in = csr_write_data;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_mv_ff <= MIN_RESET;
         max_mv_ff <= MAX_RESET;
      end else begin
         min_mv_ff <= min_mv_in;
         max_mv_ff <= max_mv_in;
      end
   end

   assign csr.min_mv = min_mv_ff;
   assign csr.max_mv = max_mv_ff;

   batt_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   batt_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .alu_in  (alu_in),
      .alu_out (alu_out),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule
